### rtl/tkf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_pkg
// Shared types and constants for the top-k frequent values block.
// ----------------------------------------------------------------------------
package tkf_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int COUNT_WIDTH   = 16;
  localparam int CFG_WIDTH     = 5;
  localparam int TABLE_DEPTH_D = 256;
  localparam int MAX_TOP_D     = 16;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] sample_value;
    logic                          set_end;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] ranked_value;
    logic [COUNT_WIDTH-1:0]        occurrences;
    logic                          final_result;
    logic                          table_overflow;
  } out_item_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LRD  = 7'b0000010,
    ST_LCMP = 7'b0000100,
    ST_INS  = 7'b0001000,
    ST_ERD  = 7'b0010000,
    ST_ECMP = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

endpackage

### rtl/top_k_frequent_values_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_frequent_values_top
// Counts distinct values of a set and emits the k most frequent ones.
// ----------------------------------------------------------------------------
// Usage:
//   in channel carries one value per transaction; set_end marks the last one.
//   cfg channel writes top_count (k); always ready, write only while idle.
//   out gives min(k clamped to 1..MAX_TOP, distinct values) results at set end,
//   highest count first, larger value first on ties, final_result on last.
// Operation:
//   a value scans the table up to a match, reading then comparing each
//   stored entry through the shared read address of both RAMs.
//   each result costs another full scan of the table, plus the handshake.
//   the block takes one transaction at a time; in_ready is low meanwhile.
// Reset:
//   clears the entry count, the overflow flag and sets k to 1; the table
//   needs no clearing pass.
// Stall:
//   a result holds on out until out_ready; nothing else advances.
// ----------------------------------------------------------------------------
module top_k_frequent_values_top #(
  parameter int TABLE_DEPTH = tkf_pkg::TABLE_DEPTH_D,
  parameter int MAX_TOP     = tkf_pkg::MAX_TOP_D
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tkf_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tkf_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tkf_pkg::CFG_WIDTH-1:0]    cfg_data
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int VW = tkf_pkg::VALUE_WIDTH;
  localparam int CW = tkf_pkg::COUNT_WIDTH;

  tkf_pkg::state_t state;
  logic [tkf_pkg::CFG_WIDTH-1:0] top_count;
  logic [UW-1:0] used;
  logic [UW-1:0] idx;
  logic [UW-1:0] rank;
  logic [UW-1:0] n_out;
  logic          ovf;
  logic [VW-1:0] cur_val;
  logic          cur_end;
  logic [VW-1:0] best_val;
  logic [CW-1:0] best_cnt;
  logic          found;
  logic [VW-1:0] prev_val;
  logic [CW-1:0] prev_cnt;
  logic          have_prev;

  logic [VW-1:0] rd_val;
  logic [CW-1:0] rd_cnt;
  logic          val_we;
  logic          cnt_we;
  logic [IW-1:0] waddr;
  logic [CW-1:0] cnt_wdata;
  logic          prev_gt;
  logic          cand_gt;
  logic          last_idx;
  logic          is_final;
  int            k_eff;
  int            n_calc;

  tkf_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(waddr), .wdata(cur_val),
    .raddr(idx[IW-1:0]), .rdata(rd_val)
  );

  tkf_ram #(.WIDTH(CW), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(waddr), .wdata(cnt_wdata),
    .raddr(idx[IW-1:0]), .rdata(rd_cnt)
  );

  tkf_rank_cmp u_prev_cmp (
    .a_cnt(prev_cnt), .a_val(prev_val), .b_cnt(rd_cnt), .b_val(rd_val), .gt(prev_gt)
  );

  tkf_rank_cmp u_best_cmp (
    .a_cnt(rd_cnt), .a_val(rd_val), .b_cnt(best_cnt), .b_val(best_val), .gt(cand_gt)
  );

  assign in_ready  = (state == tkf_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state == tkf_pkg::ST_OUT);
  assign last_idx  = (idx + UW'(1)) == used;
  assign is_final  = (rank + UW'(1)) == n_out;

  assign out_data.ranked_value   = best_val;
  assign out_data.occurrences    = best_cnt;
  assign out_data.final_result   = is_final;
  assign out_data.table_overflow = ovf;

  always_comb begin
    val_we    = 1'b0;
    cnt_we    = 1'b0;
    waddr     = idx[IW-1:0];
    cnt_wdata = (rd_cnt == tkf_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + CW'(1);
    if (state == tkf_pkg::ST_LCMP && rd_val == cur_val) begin
      cnt_we = 1'b1;
    end else if (state == tkf_pkg::ST_INS && int'(used) < TABLE_DEPTH) begin
      val_we    = 1'b1;
      cnt_we    = 1'b1;
      waddr     = used[IW-1:0];
      cnt_wdata = CW'(1);
    end
  end

  always_comb begin
    k_eff = int'(top_count);
    if (k_eff == 0) begin
      k_eff = 1;
    end else if (k_eff > MAX_TOP) begin
      k_eff = MAX_TOP;
    end
    n_calc = (int'(used) < k_eff) ? int'(used) : k_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tkf_pkg::ST_IDLE;
      top_count <= tkf_pkg::CFG_WIDTH'(1);
      used      <= '0;
      ovf       <= 1'b0;
      idx       <= '0;
      rank      <= '0;
      n_out     <= '0;
      found     <= 1'b0;
      have_prev <= 1'b0;
    end else begin
      if (cfg_valid) begin
        top_count <= cfg_data;
      end
      case (state)
        tkf_pkg::ST_IDLE: begin
          if (in_valid) begin
            cur_val <= in_data.sample_value;
            cur_end <= in_data.set_end;
            idx     <= '0;
            state   <= (used == '0) ? tkf_pkg::ST_INS : tkf_pkg::ST_LRD;
          end
        end
        tkf_pkg::ST_LRD: begin
          state <= tkf_pkg::ST_LCMP;
        end
        tkf_pkg::ST_LCMP: begin
          if (rd_val == cur_val || last_idx) begin
            if (rd_val != cur_val) begin
              state <= tkf_pkg::ST_INS;
            end else if (cur_end) begin
              idx       <= '0;
              rank      <= '0;
              found     <= 1'b0;
              have_prev <= 1'b0;
              n_out     <= UW'(n_calc);
              state     <= tkf_pkg::ST_ERD;
            end else begin
              state <= tkf_pkg::ST_IDLE;
            end
          end else begin
            idx   <= idx + UW'(1);
            state <= tkf_pkg::ST_LRD;
          end
        end
        tkf_pkg::ST_INS: begin
          if (int'(used) < TABLE_DEPTH) begin
            used <= used + UW'(1);
          end else begin
            ovf <= 1'b1;
          end
          if (cur_end) begin
            idx       <= '0;
            rank      <= '0;
            found     <= 1'b0;
            have_prev <= 1'b0;
            n_out     <= (int'(used) < TABLE_DEPTH && int'(used) < k_eff) ?
                         used + UW'(1) : UW'(n_calc);
            state     <= tkf_pkg::ST_ERD;
          end else begin
            state <= tkf_pkg::ST_IDLE;
          end
        end
        tkf_pkg::ST_ERD: begin
          state <= tkf_pkg::ST_ECMP;
        end
        tkf_pkg::ST_ECMP: begin
          if ((!have_prev || prev_gt) && (!found || cand_gt)) begin
            best_val <= rd_val;
            best_cnt <= rd_cnt;
            found    <= 1'b1;
          end
          if (last_idx) begin
            state <= tkf_pkg::ST_OUT;
          end else begin
            idx   <= idx + UW'(1);
            state <= tkf_pkg::ST_ERD;
          end
        end
        tkf_pkg::ST_OUT: begin
          if (out_ready) begin
            prev_val  <= best_val;
            prev_cnt  <= best_cnt;
            have_prev <= 1'b1;
            found     <= 1'b0;
            idx       <= '0;
            rank      <= rank + UW'(1);
            if (is_final) begin
              used  <= '0;
              ovf   <= 1'b0;
              state <= tkf_pkg::ST_IDLE;
            end else begin
              state <= tkf_pkg::ST_ERD;
            end
          end
        end
        default: begin
          state <= tkf_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/tkf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tkf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tkf_rank_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_rank_cmp
// Ranks two (count, signed value) pairs: gt is high when a outranks b.
// ----------------------------------------------------------------------------
module tkf_rank_cmp (
  input  logic [tkf_pkg::COUNT_WIDTH-1:0] a_cnt,
  input  logic [tkf_pkg::VALUE_WIDTH-1:0] a_val,
  input  logic [tkf_pkg::COUNT_WIDTH-1:0] b_cnt,
  input  logic [tkf_pkg::VALUE_WIDTH-1:0] b_val,
  output logic                            gt
);

  logic [tkf_pkg::COUNT_WIDTH+tkf_pkg::VALUE_WIDTH-1:0] a_key;
  logic [tkf_pkg::COUNT_WIDTH+tkf_pkg::VALUE_WIDTH-1:0] b_key;

  // flip the sign bit so an unsigned compare orders signed values
  assign a_key = {a_cnt, ~a_val[tkf_pkg::VALUE_WIDTH-1], a_val[tkf_pkg::VALUE_WIDTH-2:0]};
  assign b_key = {b_cnt, ~b_val[tkf_pkg::VALUE_WIDTH-1], b_val[tkf_pkg::VALUE_WIDTH-2:0]};
  assign gt    = a_key > b_key;

endmodule

### rtl/tkf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_checker
// Port level checks for the top-k frequent values block.
// ----------------------------------------------------------------------------
module tkf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tkf_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a transaction");

  a_more_results: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.final_result |=> !in_ready)
    else $error("run ended before final result");

endmodule

bind top_k_frequent_values_top tkf_checker u_tkf_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the top-k frequent values block: sends sets of signed values,
// predicts the ranked results with a behavioral table model and compares
// every output transaction field by field, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int TDEPTH    = tkf_pkg::TABLE_DEPTH_D;
  localparam int KMAX      = tkf_pkg::MAX_TOP_D;
  localparam int EXP_DEPTH = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tkf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tkf_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tkf_pkg::CFG_WIDTH-1:0] cfg_data = '0;

  top_k_frequent_values_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [tkf_pkg::VALUE_WIDTH-1:0] tbl_val [TDEPTH];
  logic [tkf_pkg::COUNT_WIDTH-1:0]        tbl_cnt [TDEPTH];
  bit                                     tbl_done [TDEPTH];
  int                                     tbl_used;
  bit                                     tbl_ovf;
  logic [tkf_pkg::CFG_WIDTH-1:0]          k_reg;

  // expected results, in order
  tkf_pkg::out_item_t exp_mem [EXP_DEPTH];
  int  exp_wr = 0;
  int  exp_rd = 0;
  int  errors;
  bit  send_gaps = 1'b1;
  bit  recv_gaps = 1'b1;
  int  hold_cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  task automatic add_expected(input tkf_pkg::out_item_t e);
    exp_mem[exp_wr % EXP_DEPTH] = e;
    exp_wr++;
  endtask

  task automatic predict_sample(input tkf_pkg::in_item_t it);
    int i, r, n, best, k;
    bit hit;
    tkf_pkg::out_item_t e;
    hit = 1'b0;
    for (i = 0; i < tbl_used; i++) begin
      if (!hit && tbl_val[i] == it.sample_value) begin
        if (tbl_cnt[i] != tkf_pkg::COUNT_MAX) tbl_cnt[i]++;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (tbl_used < TDEPTH) begin
        tbl_val[tbl_used] = it.sample_value;
        tbl_cnt[tbl_used] = tkf_pkg::COUNT_WIDTH'(1);
        tbl_done[tbl_used] = 1'b0;
        tbl_used++;
      end else begin
        tbl_ovf = 1'b1;
      end
    end
    if (!it.set_end) return;
    k = (k_reg == 0) ? 1 : (k_reg > KMAX) ? KMAX : int'(k_reg);
    n = (tbl_used < k) ? tbl_used : k;
    for (r = 0; r < n; r++) begin
      best = -1;
      for (i = 0; i < tbl_used; i++) begin
        if (tbl_done[i]) continue;
        if (best < 0 || tbl_cnt[i] > tbl_cnt[best] ||
            (tbl_cnt[i] == tbl_cnt[best] && tbl_val[i] > tbl_val[best])) best = i;
      end
      tbl_done[best] = 1'b1;
      e.ranked_value   = tbl_val[best];
      e.occurrences    = tbl_cnt[best];
      e.final_result   = (r == n - 1);
      e.table_overflow = tbl_ovf;
      add_expected(e);
    end
    tbl_used = 0;
    tbl_ovf = 1'b0;
    for (i = 0; i < TDEPTH; i++) tbl_done[i] = 1'b0;
  endtask

  task automatic send_sample(input logic signed [tkf_pkg::VALUE_WIDTH-1:0] v, input bit last);
    tkf_pkg::in_item_t it;
    it.sample_value = v;
    it.set_end = last;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sample(it);
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (exp_wr != exp_rd && guard < 2000000) begin
      @(negedge clk);
      guard++;
    end
    repeat (600) @(negedge clk);
  endtask

  task automatic write_k(input logic [tkf_pkg::CFG_WIDTH-1:0] k);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    k_reg = k;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // output checking
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (exp_wr == exp_rd) begin
        report("unexpected transaction", 64'(out_data), 64'd0);
      end else begin
        tkf_pkg::out_item_t e;
        e = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_data.ranked_value !== e.ranked_value)
          report("ranked_value", 64'(out_data.ranked_value), 64'(e.ranked_value));
        if (out_data.occurrences !== e.occurrences)
          report("occurrences", 64'(out_data.occurrences), 64'(e.occurrences));
        if (out_data.final_result !== e.final_result)
          report("final_result", 64'(out_data.final_result), 64'(e.final_result));
        if (out_data.table_overflow !== e.table_overflow)
          report("table_overflow", 64'(out_data.table_overflow), 64'(e.table_overflow));
      end
    end
  end

  // receiver readiness
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      hold_cycles = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic test_extremes();
    write_k(5'd16);
    send_sample(32'sh7fffffff, 1'b0);
    send_sample(-32'sh80000000, 1'b0);
    send_sample(-32'sh80000000, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(32'sh7fffffff, 1'b0);
    send_sample(5, 1'b1);
    send_sample(42, 1'b1);
  endtask

  task automatic test_ties_and_k();
    write_k(5'd0);
    send_sample(3, 1'b0);
    send_sample(-3, 1'b1);
    write_k(5'd31);
    for (int i = 0; i < 20; i++) send_sample(i - 10, i == 19);
    write_k(5'd1);
    send_sample(7, 1'b0);
    send_sample(9, 1'b0);
    send_sample(8, 1'b1);
  endtask

  task automatic test_overflow();
    write_k(5'd4);
    for (int i = 0; i < 258; i++) send_sample(i * 3 - 300, 1'b0);
    send_sample(-300, 1'b0);
    send_sample(99999, 1'b1);
  endtask

  task automatic test_backpressure();
    write_k(5'd16);
    hold_cycles = 3000;
    for (int i = 0; i < 16; i++) send_sample(i, 1'b0);
    send_sample(100, 1'b1);
    send_sample(1, 1'b1);
    drain();
  endtask

  task automatic test_random();
    int items, len, pool, base;
    items = 0;
    while (items < 100) begin
      write_k(5'($urandom_range(1, 16)));
      len = $urandom_range(1, 24);
      pool = $urandom_range(1, 8);
      base = $urandom;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send_sample($urandom, i == len - 1);
        else send_sample(base + $urandom_range(0, pool - 1), i == len - 1);
      end
      items += len;
      if (items > 60) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end
    end
  endtask

  initial begin
    errors = 0;
    tbl_used = 0;
    tbl_ovf = 1'b0;
    k_reg = tkf_pkg::CFG_WIDTH'(1);
    for (int i = 0; i < TDEPTH; i++) tbl_done[i] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_sample(-5, 1'b1);
    test_extremes();
    test_ties_and_k();
    test_overflow();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule
